// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Operation codes on the request channel.
  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned PrioWidth  = 16;
  localparam int unsigned CountWidth = 5;

  // One stored queue entry.
  typedef struct packed {
    logic signed [DataWidth-1:0] data;
    logic [PrioWidth-1:0]        prio;
  } entry_t;

  // One result as handed from the controller to the output stage.
  typedef struct packed {
    logic signed [DataWidth-1:0] data;
    status_e                     status;
    logic                        is_empty;
    logic [CountWidth-1:0]       entry_count;
  } rsp_t;

endpackage

// ===== hdl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels for queue operations and their results.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] data_in;
  logic [15:0]        priority_in;

  modport source (output valid, kind, data_in, priority_in, input ready);
  modport sink   (input valid, kind, data_in, priority_in, output ready);
endinterface

interface spq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data_out;
  logic [1:0]         status;
  logic               is_empty;
  logic [4:0]         entry_count;

  modport source (output valid, data_out, status, is_empty, entry_count, input ready);
  modport sink   (input valid, data_out, status, is_empty, entry_count, output ready);
endinterface

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue, smallest priority served first, ties in FIFO order.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation per transfer: kind (push, pop, peek), the
//   data word and the priority of a push. rsp_o returns exactly one result
//   per operation, in order: front data for a pop or peek, a status, the
//   empty flag and the entry count after the operation.
//   Entries live in a circular buffer in a single-port-write, single-port-
//   read store with registered read data; the controller works on one
//   operation at a time.
//   No stored entry is read or moved for an empty read, a push into an
//   empty or full queue or the unused code; a pop or peek reads the front,
//   and any other push walks past every stored entry with a larger priority
//   (one store read and write per moved entry).
//   A new request is taken in the cycle after the previous result leaves
//   the controller; the output register lets it start while that result
//   still waits on rsp_o.
//   Reset empties the queue at once; no clearing pass is needed.
//   While the receiver stalls, the finished result stays on rsp_o and the
//   next one waits in the controller.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          rsp_valid;
  logic          rsp_ready;
  rsp_t          rsp;
  logic          out_valid_q;
  rsp_t          out_q;

  spq_ram #(
    .Depth (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  spq_ctrl #(
    .Depth (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_kind_i  (req_i.kind),
    .req_data_i  (req_i.data_in),
    .req_prio_i  (req_i.priority_in),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Output register: takes a result when empty or when its content transfers.
  assign rsp_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.data_out    = out_q.data;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.is_empty    = out_q.is_empty;
  assign rsp_o.entry_count = out_q.entry_count;

endmodule

// ===== hdl/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_ram
  import spq_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for the sorted queue. Entries sit in a circular buffer in the
// entry store; a push walks back from the tail one entry per cycle, moving
// larger priorities up by one slot until the insertion point is found.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [1:0]                  req_kind_i,
  input  logic signed [DataWidth-1:0] req_data_i,
  input  logic [PrioWidth-1:0]        req_prio_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output rsp_t                        rsp_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output entry_t                      mem_wdata_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  entry_t                      mem_rdata_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FRONT = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_PLACE = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  localparam logic [CW:0]   DepthS = (CW+1)'(Depth);
  localparam logic [CW-1:0] DepthC = CW'(Depth);
  localparam logic [AW-1:0] LastA  = AW'(Depth - 1);

  state_e                      state_q, state_d;
  logic [AW-1:0]               head_q, head_d;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               off_q, off_d;
  logic                        pop_q, pop_d;
  entry_t                      new_q, new_d;
  logic signed [DataWidth-1:0] rdata_q, rdata_d;
  status_e                     status_q, status_d;
  logic [CW+CountWidth-1:0]    count_ext;

  // Map a position counted from the queue front to a store address.
  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + {1'b0, off};
    if (sum >= DepthS) begin
      sum = sum - DepthS;
    end
    return sum[AW-1:0];
  endfunction

  // Next-state logic and store accesses.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    off_d       = off_q;
    pop_d       = pop_q;
    new_d       = new_q;
    rdata_d     = rdata_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = to_phys(head_q, off_q);
    mem_wdata_o = new_q;
    mem_raddr_o = head_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          rdata_d  = '0;
          status_d = STATUS_OK;
          state_d  = ST_RESP;
          if (req_kind_i == KIND_PUSH) begin
            new_d = '{data: req_data_i, prio: req_prio_i};
            if (count_q == DepthC) begin
              status_d = STATUS_FULL;
            end else if (count_q == '0) begin
              // First entry goes straight to the front.
              mem_we_o    = 1'b1;
              mem_waddr_o = head_q;
              mem_wdata_o = new_d;
              count_d     = count_q + 1'b1;
            end else begin
              mem_raddr_o = to_phys(head_q, count_q - 1'b1);
              off_d       = count_q;
              state_d     = ST_SHIFT;
            end
          end else if (req_kind_i == KIND_POP || req_kind_i == KIND_PEEK) begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
            end else begin
              pop_d   = (req_kind_i == KIND_POP);
              state_d = ST_FRONT;
            end
          end
        end
      end

      ST_FRONT: begin
        rdata_d = mem_rdata_i.data;
        if (pop_q) begin
          head_d  = (head_q == LastA) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
        end
        state_d = ST_RESP;
      end

      ST_SHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = to_phys(head_q, off_q);
        if (mem_rdata_i.prio > new_q.prio) begin
          // Move the larger entry up one slot and keep walking back.
          mem_wdata_o = mem_rdata_i;
          off_d       = off_q - 1'b1;
          if (off_q == CW'(1)) begin
            state_d = ST_PLACE;
          end else begin
            mem_raddr_o = to_phys(head_q, off_q - CW'(2));
          end
        end else begin
          mem_wdata_o = new_q;
          count_d     = count_q + 1'b1;
          state_d     = ST_RESP;
        end
      end

      ST_PLACE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = head_q;
        mem_wdata_o = new_q;
        count_d     = count_q + 1'b1;
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      off_q   <= '0;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      off_q   <= off_d;
      pop_q   <= pop_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    new_q    <= new_d;
    rdata_q  <= rdata_d;
    status_q <= status_d;
  end

  // The reported count is the stored count masked to the port width.
  assign count_ext   = (CW+CountWidth)'(count_q);
  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = (state_q == ST_RESP);
  assign rsp_o       = '{data:        rdata_q,
                         status:      status_q,
                         is_empty:    (count_q == '0),
                         entry_count: count_ext[CountWidth-1:0]};

  // The stored count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("stored count exceeds queue depth");

  // The front pointer stays inside the store.
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastA)
    else $error("front pointer outside the store");

  // No store write while reading the front or presenting a result.
  a_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FRONT || state_q == ST_RESP) |-> !mem_we_o)
    else $error("store written outside a push");

  // A pop that reaches the front removes exactly one entry.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FRONT && pop_q) |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not remove one entry");

endmodule
